// ===== hdl/vrsd_pkg.sv =====
// Shared widths, register codes and reset values for the vibration run/stop detector.
package vrsd_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int COUNT_WIDTH  = 21;
    localparam int JITTER_WIDTH = 16;
    localparam int LIMIT_WIDTH  = 16;
    localparam int CLEAR_WIDTH  = 20;
    localparam int CFG_WIDTH    = 20;
    localparam int CFG_IDX_WIDTH = 2;

    localparam logic [JITTER_WIDTH-1:0] JITTER_RESET = JITTER_WIDTH'(500);
    localparam logic [LIMIT_WIDTH-1:0]  LIMIT_RESET  = LIMIT_WIDTH'(20);
    localparam logic [CLEAR_WIDTH-1:0]  CLEAR_RESET  = CLEAR_WIDTH'(144000);

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_JITTER = 2'd0,
        CFG_LIMIT  = 2'd1,
        CFG_CLEAR  = 2'd2
    } cfg_idx_t;

    // Motion stage result handed to the run-state stage.
    typedef struct packed {
        logic valid;
        logic motion;
    } motion_t;

endpackage

// ===== hdl/vrsd_motion.sv =====
// Sample stage: per-axis absolute change against the previous sample and the motion flag.
module vrsd_motion
    import vrsd_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic                           advance,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_z,
    input  logic [JITTER_WIDTH-1:0]        jitter_threshold,
    output motion_t                        stage
);

    logic signed [SAMPLE_WIDTH-1:0] prev_x_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_y_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_z_reg;
    logic                           valid_reg;
    logic                           valid_next;
    logic                           motion_reg;
    logic                           motion_next;

    function automatic logic [SAMPLE_WIDTH:0] abs_change(
        input logic signed [SAMPLE_WIDTH-1:0] now_s,
        input logic signed [SAMPLE_WIDTH-1:0] old_s
    );
        logic signed [SAMPLE_WIDTH:0] d;
        begin
            d = (SAMPLE_WIDTH+1)'(now_s) - (SAMPLE_WIDTH+1)'(old_s);
            abs_change = d[SAMPLE_WIDTH] ? (SAMPLE_WIDTH+1)'(-d) : (SAMPLE_WIDTH+1)'(d);
        end
    endfunction

    always_comb
    begin
        motion_next = (abs_change(accel_x, prev_x_reg) > (SAMPLE_WIDTH+1)'(jitter_threshold))
                   || (abs_change(accel_y, prev_y_reg) > (SAMPLE_WIDTH+1)'(jitter_threshold))
                   || (abs_change(accel_z, prev_z_reg) > (SAMPLE_WIDTH+1)'(jitter_threshold));
    end

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            prev_z_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
            begin
                prev_x_reg <= accel_x;
                prev_y_reg <= accel_y;
                prev_z_reg <= accel_z;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            motion_reg <= motion_next;
        end
    end

    assign stage.valid  = valid_reg;
    assign stage.motion = motion_reg;

endmodule

// ===== hdl/vrsd_run_state.sv =====
// Run-state stage: moving/still run counters, running flag and the result register.
module vrsd_run_state
    import vrsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  motion_t                stage,
    input  logic                   out_stall,
    input  logic [LIMIT_WIDTH-1:0] state_limit,
    input  logic [CLEAR_WIDTH-1:0] clear_limit,
    output logic                   advance,
    output logic                   out_valid,
    output logic                   machine_running,
    output logic                   state_changed,
    output logic                   motion_seen
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] moving_count_reg;
    logic [COUNT_WIDTH-1:0] moving_count_next;
    logic [COUNT_WIDTH-1:0] still_count_reg;
    logic [COUNT_WIDTH-1:0] still_count_next;
    logic                   last_moving_reg;
    logic                   last_moving_next;
    logic                   running_reg;
    logic                   running_next;
    logic                   changed_reg;
    logic                   changed_next;
    logic                   motion_reg;
    logic                   out_valid_reg;
    logic                   load;
    logic [COUNT_WIDTH-1:0] mov_a;
    logic [COUNT_WIDTH-1:0] still_a;
    logic [COUNT_WIDTH-1:0] mov_b;
    logic [COUNT_WIDTH-1:0] still_b;
    logic [COUNT_WIDTH-1:0] limit_ext;
    logic [COUNT_WIDTH-1:0] clear_ext;

    assign advance   = !out_valid_reg || !out_stall;
    assign load      = advance && stage.valid;
    assign limit_ext = COUNT_WIDTH'(state_limit);
    assign clear_ext = COUNT_WIDTH'(clear_limit);

    always_comb
    begin
        mov_a            = moving_count_reg;
        still_a          = still_count_reg;
        last_moving_next = last_moving_reg;
        if (stage.motion)
        begin
            if (last_moving_reg)
            begin
                mov_a = (moving_count_reg == COUNT_MAX) ? COUNT_MAX
                                                        : moving_count_reg + 1'b1;
            end
            else
            begin
                still_a          = '0;
                last_moving_next = 1'b1;
            end
        end
        else
        begin
            if (last_moving_reg)
            begin
                last_moving_next = 1'b0;
                mov_a            = '0;
            end
            else
            begin
                still_a = (still_count_reg == COUNT_MAX) ? COUNT_MAX
                                                         : still_count_reg + 1'b1;
            end
        end

        // hysteresis: flip only after a run longer than the state limit
        mov_b        = mov_a;
        still_b      = still_a;
        running_next = running_reg;
        changed_next = 1'b0;
        if ((mov_a > limit_ext) && !running_reg)
        begin
            running_next = 1'b1;
            still_b      = '0;
            changed_next = 1'b1;
        end
        else if ((still_a > limit_ext) && running_reg)
        begin
            running_next = 1'b0;
            mov_b        = '0;
            changed_next = 1'b1;
        end

        if ((mov_b > clear_ext) || (still_b > clear_ext))
        begin
            moving_count_next = '0;
            still_count_next  = '0;
        end
        else
        begin
            moving_count_next = mov_b;
            still_count_next  = still_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moving_count_reg <= '0;
            still_count_reg  <= '0;
            last_moving_reg  <= 1'b0;
            running_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                moving_count_reg <= moving_count_next;
                still_count_reg  <= still_count_next;
                last_moving_reg  <= last_moving_next;
                running_reg      <= running_next;
            end
            if (advance)
            begin
                out_valid_reg <= stage.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            changed_reg <= changed_next;
            motion_reg  <= stage.motion;
        end
    end

    assign out_valid       = out_valid_reg;
    assign machine_running = running_reg;
    assign state_changed   = changed_reg;
    assign motion_seen     = motion_reg;

`ifndef SYNTH
    a_still_idle_when_moving: assert property (@(posedge clk) disable iff (!rst_n)
        last_moving_reg |-> (still_count_reg == '0))
        else $error("still counter nonzero during a moving run");

    a_moving_idle_when_still: assert property (@(posedge clk) disable iff (!rst_n)
        !last_moving_reg |-> (moving_count_reg == '0))
        else $error("moving counter nonzero during a still run");

    a_change_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (changed_reg == (running_reg != $past(running_reg))))
        else $error("change pulse does not match running flag flip");
`endif

endmodule

// ===== hdl/vibration_run_stop_detector.sv =====
// Top level of the vibration run/stop detector: configuration registers and the two stages.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     accel_x, accel_y, accel_z
//   out      output     out_valid / out_stall   machine_running, state_changed, motion_seen
//   cfg      input      cfg_we                  cfg_index, cfg_data
//
// One sample per cycle while out_stall is low; a result passes from the motion stage register
// to the run-state result register and leaves at an edge where out_stall is low.
// Reset clears the previous samples, both run counters, the running flag and
// loads the default thresholds.
// in_stall rises only while both stages hold items and out_stall is high.
module vibration_run_stop_detector
    import vrsd_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_z,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           machine_running,
    output logic                           state_changed,
    output logic                           motion_seen,
    input  logic                           cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]       cfg_index,
    input  logic [CFG_WIDTH-1:0]           cfg_data
);

    logic [JITTER_WIDTH-1:0] jitter_reg;
    logic [LIMIT_WIDTH-1:0]  limit_reg;
    logic [CLEAR_WIDTH-1:0]  clear_reg;
    motion_t                 stage;
    logic                    advance;
    logic                    load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jitter_reg <= JITTER_RESET;
            limit_reg  <= LIMIT_RESET;
            clear_reg  <= CLEAR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_JITTER: jitter_reg <= cfg_data[JITTER_WIDTH-1:0];
                CFG_LIMIT:  limit_reg  <= cfg_data[LIMIT_WIDTH-1:0];
                CFG_CLEAR:  clear_reg  <= cfg_data[CLEAR_WIDTH-1:0];
                default:    ;
            endcase
        end
    end

    // hold the input while the motion stage cannot hand its item on
    assign in_stall = stage.valid && !advance;
    assign load     = in_valid && !in_stall;

    vrsd_motion u_motion (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (load),
        .advance          (advance),
        .accel_x          (accel_x),
        .accel_y          (accel_y),
        .accel_z          (accel_z),
        .jitter_threshold (jitter_reg),
        .stage            (stage)
    );

    vrsd_run_state u_run_state (
        .clk             (clk),
        .rst_n           (rst_n),
        .stage           (stage),
        .out_stall       (out_stall),
        .state_limit     (limit_reg),
        .clear_limit     (clear_reg),
        .advance         (advance),
        .out_valid       (out_valid),
        .machine_running (machine_running),
        .state_changed   (state_changed),
        .motion_seen     (motion_seen)
    );

endmodule

// ===== tb/vibration_run_stop_detector_tb.sv =====
// Testbench for the vibration run/stop detector: directed and random samples checked against a predictor.
`timescale 1ns / 100ps

module vibration_run_stop_detector_tb
    import vrsd_pkg::*;
();

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNUSED = 2'd3;
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = {COUNT_WIDTH{1'b1}};
    localparam logic [CFG_WIDTH-1:0] CFG_ALL_ONES = {CFG_WIDTH{1'b1}};
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic running;
        logic changed;
        logic motion;
    } run_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic signed [SAMPLE_WIDTH-1:0] accel_x;
    logic signed [SAMPLE_WIDTH-1:0] accel_y;
    logic signed [SAMPLE_WIDTH-1:0] accel_z;
    logic                           out_valid;
    logic                           out_stall;
    logic                           machine_running;
    logic                           state_changed;
    logic                           motion_seen;
    logic                           cfg_we;
    logic [CFG_IDX_WIDTH-1:0]       cfg_index;
    logic [CFG_WIDTH-1:0]           cfg_data;

    // Predictor state and configuration.
    logic [JITTER_WIDTH-1:0]        jitter_cfg;
    logic [LIMIT_WIDTH-1:0]         limit_cfg;
    logic [CLEAR_WIDTH-1:0]         clear_cfg;
    logic signed [SAMPLE_WIDTH-1:0] last_x, last_y, last_z;
    logic [COUNT_WIDTH-1:0]         moving_cnt, still_cnt;
    logic                           was_moving;
    logic                           running;

    run_result_t pending_results[$];

    int errors;
    int samples_sent;
    int results_checked;
    int flips_predicted;
    int settings_written;
    int stall_cycles;
    int send_gap_max;
    int recv_gap_max;
    bit hold_request;
    int hold_len;

    vibration_run_stop_detector dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .accel_x         (accel_x),
        .accel_y         (accel_y),
        .accel_z         (accel_z),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .machine_running (machine_running),
        .state_changed   (state_changed),
        .motion_seen     (motion_seen),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int unsigned axis_change(logic signed [SAMPLE_WIDTH-1:0] now,
                                                logic signed [SAMPLE_WIDTH-1:0] prior);
        int d;
        d = int'(now) - int'(prior);
        return (d < 0) ? -d : d;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] bump(logic [COUNT_WIDTH-1:0] c);
        return (c == COUNT_TOP) ? c : c + 1'b1;
    endfunction

    task automatic reset_predictor();
        jitter_cfg = JITTER_RESET;
        limit_cfg  = LIMIT_RESET;
        clear_cfg  = CLEAR_RESET;
        last_x = '0;
        last_y = '0;
        last_z = '0;
        moving_cnt = '0;
        still_cnt  = '0;
        was_moving = 1'b0;
        running    = 1'b0;
    endtask

    task automatic predict_run_state(input logic signed [SAMPLE_WIDTH-1:0] x,
                                     input logic signed [SAMPLE_WIDTH-1:0] y,
                                     input logic signed [SAMPLE_WIDTH-1:0] z);
        run_result_t r;
        logic motion;
        motion = (axis_change(x, last_x) > jitter_cfg) ||
                 (axis_change(y, last_y) > jitter_cfg) ||
                 (axis_change(z, last_z) > jitter_cfg);
        last_x = x;
        last_y = y;
        last_z = z;
        r.changed = 1'b0;
        if (motion)
        begin
            if (was_moving)
                moving_cnt = bump(moving_cnt);
            else
            begin
                still_cnt  = '0;
                was_moving = 1'b1;
            end
        end
        else
        begin
            if (was_moving)
            begin
                was_moving = 1'b0;
                moving_cnt = '0;
            end
            else
                still_cnt = bump(still_cnt);
        end
        if (moving_cnt > limit_cfg && !running)
        begin
            running   = 1'b1;
            still_cnt = '0;
            r.changed = 1'b1;
        end
        else if (still_cnt > limit_cfg && running)
        begin
            running    = 1'b0;
            moving_cnt = '0;
            r.changed  = 1'b1;
        end
        if (moving_cnt > clear_cfg || still_cnt > clear_cfg)
        begin
            moving_cnt = '0;
            still_cnt  = '0;
        end
        r.running = running;
        r.motion  = motion;
        if (r.changed)
            flips_predicted++;
        pending_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic got, input logic want);
        $display("mismatch at %0t ns: %s got %b expected %b", $time, what, got, want);
        errors++;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] x,
                               input logic signed [SAMPLE_WIDTH-1:0] y,
                               input logic signed [SAMPLE_WIDTH-1:0] z);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        accel_x  <= x;
        accel_y  <= y;
        accel_z  <= z;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        samples_sent++;
        predict_run_state(x, y, z);
    endtask

    // Lower valid, then wait for every pending result and the pipeline latency.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_JITTER: jitter_cfg = value[JITTER_WIDTH-1:0];
            CFG_LIMIT:  limit_cfg  = value[LIMIT_WIDTH-1:0];
            CFG_CLEAR:  clear_cfg  = value[CLEAR_WIDTH-1:0];
            default:    ;
        endcase
        settings_written++;
    endtask

    task automatic set_config(input logic [JITTER_WIDTH-1:0] j,
                              input logic [LIMIT_WIDTH-1:0] l,
                              input logic [CLEAR_WIDTH-1:0] c);
        drain();
        write_reg(CFG_JITTER, CFG_WIDTH'(j));
        write_reg(CFG_LIMIT, CFG_WIDTH'(l));
        write_reg(CFG_CLEAR, CFG_WIDTH'(c));
    endtask

    function automatic logic signed [SAMPLE_WIDTH-1:0] clamp_sample(int v);
        if (v > int'(SAMPLE_MAX))
            return SAMPLE_MAX;
        if (v < int'(SAMPLE_MIN))
            return SAMPLE_MIN;
        return v[SAMPLE_WIDTH-1:0];
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] nudge(logic signed [SAMPLE_WIDTH-1:0] base,
                                                             int spread);
        return clamp_sample(int'(base) + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // Half the time jump anywhere; else step one axis just past the threshold where it fits, else jump anywhere.
    function automatic logic signed [SAMPLE_WIDTH-1:0] kick(logic signed [SAMPLE_WIDTH-1:0] base);
        int step;
        step = int'(jitter_cfg) + 1;
        if ($urandom_range(0, 1) == 0)
            return SAMPLE_WIDTH'($urandom());
        if (int'(base) + step <= int'(SAMPLE_MAX))
            return SAMPLE_WIDTH'(int'(base) + step);
        if (int'(base) - step >= int'(SAMPLE_MIN))
            return SAMPLE_WIDTH'(int'(base) - step);
        return SAMPLE_WIDTH'($urandom());
    endfunction

    task automatic send_run(input bit moving, input int count);
        logic signed [SAMPLE_WIDTH-1:0] x, y, z;
        int spread;
        int axis;
        spread = (jitter_cfg > 2000) ? 2000 : int'(jitter_cfg);
        repeat (count)
        begin
            x = nudge(last_x, spread);
            y = nudge(last_y, spread);
            z = nudge(last_z, spread);
            if (moving)
            begin
                axis = $urandom_range(0, 2);
                case (axis)
                    0:       x = kick(last_x);
                    1:       y = kick(last_y);
                    default: z = kick(last_z);
                endcase
            end
            send_sample(x, y, z);
        end
    endtask

    task automatic test_reset_defaults();
        send_sample('0, '0, '0);
        // change equal to the threshold is not motion
        send_sample(SAMPLE_WIDTH'(500), '0, '0);
        send_sample(SAMPLE_WIDTH'(1001), SAMPLE_WIDTH'(-501), '0);
        send_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
        send_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        drain();
    endtask

    task automatic test_register_writes();
        write_reg(CFG_JITTER, {4'hF, {JITTER_WIDTH{1'b0}}});   // only the low bits stick
        write_reg(CFG_UNUSED, CFG_ALL_ONES);
        write_reg(CFG_LIMIT, '0);
        write_reg(CFG_CLEAR, '0);
        send_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        send_sample(SAMPLE_MAX - SAMPLE_WIDTH'(1), SAMPLE_MIN, SAMPLE_MAX);
        send_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        send_sample(SAMPLE_MAX, SAMPLE_MIN + SAMPLE_WIDTH'(1), SAMPLE_MAX);
        send_sample(SAMPLE_MAX, SAMPLE_MIN + SAMPLE_WIDTH'(1), SAMPLE_MAX);
        send_sample(SAMPLE_MAX, SAMPLE_MIN + SAMPLE_WIDTH'(1), SAMPLE_MAX);
        drain();
    endtask

    task automatic test_run_stop();
        set_config(JITTER_WIDTH'(100), LIMIT_WIDTH'(2), {CLEAR_WIDTH{1'b1}});
        send_run(1'b1, 5);
        send_run(1'b0, 5);
        set_config(JITTER_WIDTH'(100), LIMIT_WIDTH'(10), CLEAR_WIDTH'(3));
        send_run(1'b0, 6);
        drain();
    endtask

    task automatic test_backpressure();
        send_gap_max = 0;
        hold_len     = 50;
        hold_request = 1'b1;
        send_run(1'b1, 15);
        send_run(1'b0, 15);
        drain();
        send_gap_max = 3;
    endtask

    task automatic run_phase(input int count);
        int lim;
        int done;
        int n;
        bit moving;
        lim = (limit_cfg > 15) ? 15 : int'(limit_cfg);
        done = 0;
        moving = $urandom_range(0, 1);
        while (done < count)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                n = $urandom_range(1, 3);
                repeat (n) send_sample(SAMPLE_WIDTH'($urandom()), SAMPLE_WIDTH'($urandom()),
                                       SAMPLE_WIDTH'($urandom()));
            end
            else
            begin
                moving = ~moving;
                n = $urandom_range(1, 2 * lim + 4);
                send_run(moving, n);
            end
            done += n;
        end
    endtask

    task automatic test_random_runs();
        logic [CLEAR_WIDTH-1:0] c;
        set_config('0, '0, '0);
        run_phase(100);
        set_config({JITTER_WIDTH{1'b1}}, {LIMIT_WIDTH{1'b1}}, {CLEAR_WIDTH{1'b1}});
        run_phase(80);
        // back-to-back items on both sides
        send_gap_max = 0;
        recv_gap_max = 0;
        set_config(JITTER_WIDTH'($urandom_range(0, 1500)), LIMIT_WIDTH'($urandom_range(0, 10)),
                   {CLEAR_WIDTH{1'b1}});
        run_phase(100);
        send_gap_max = 3;
        recv_gap_max = 3;
        repeat (6)
        begin
            case ($urandom_range(0, 2))
                0:       c = CLEAR_WIDTH'($urandom_range(0, 40));
                1:       c = {CLEAR_WIDTH{1'b1}};
                default: c = CLEAR_WIDTH'($urandom());
            endcase
            set_config(($urandom_range(0, 7) == 0) ? JITTER_WIDTH'($urandom())
                                                   : JITTER_WIDTH'($urandom_range(0, 3000)),
                       LIMIT_WIDTH'($urandom_range(0, 15)), c);
            run_phase(90);
        end
        drain();
    endtask

    // Receiver: random stalls per item, and a long hold when asked.
    initial
    begin : receiver
        int gap;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (hold_len) @(negedge clk);
            end
            else
            begin
                gap = $urandom_range(0, recv_gap_max);
                if (gap > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (gap) @(negedge clk);
                end
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
        end
    end

    initial
    begin : result_checker
        run_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1)
            begin
                if (in_valid === 1'b1 && in_stall === 1'b1)
                    stall_cycles++;
                if (out_valid === 1'b1 && out_stall === 1'b0)
                begin
                    if (pending_results.size() == 0)
                        report_mismatch("result with nothing pending, machine_running",
                                        machine_running, 1'bx);
                    else
                    begin
                        want = pending_results.pop_front();
                        results_checked++;
                        if (machine_running !== want.running)
                            report_mismatch("machine_running", machine_running, want.running);
                        if (state_changed !== want.changed)
                            report_mismatch("state_changed", state_changed, want.changed);
                        if (motion_seen !== want.motion)
                            report_mismatch("motion_seen", motion_seen, want.motion);
                    end
                end
            end
        end
    end

    initial
    begin
        errors           = 0;
        samples_sent     = 0;
        results_checked  = 0;
        flips_predicted  = 0;
        settings_written = 0;
        stall_cycles     = 0;
        send_gap_max     = 3;
        recv_gap_max     = 3;
        hold_request     = 1'b0;
        hold_len         = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        accel_x   = '0;
        accel_y   = '0;
        accel_z   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_JITTER;
        cfg_data  = '0;
        reset_predictor();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_writes();
        test_run_stop();
        test_backpressure();
        test_random_runs();

        $display("covered %0d samples, %0d results checked, %0d run/stop flips",
                 samples_sent, results_checked, flips_predicted);
        $display("%0d register writes, %0d cycles with the input held off",
                 settings_written, stall_cycles);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
